### design/hvbp_pkg.sv
// Package for the history and value branch predictor.
// Holds the table sizes, the two-bit counter codes and the request/result structs.
// No dependencies.
package hvbp_pkg;

  localparam int HISTORY_LEN         = 12;
  localparam int VALUE_HISTORY_DEPTH = 8;
  localparam int VALUE_W             = 8;
  localparam int VIDX_W              = 8;
  localparam int PIDX_W              = HISTORY_LEN - 1;
  localparam int PAT_DEPTH           = 1 << PIDX_W;
  localparam int VAL_DEPTH           = 1 << VIDX_W;
  localparam int CLR_W               = (PIDX_W > VIDX_W) ? PIDX_W : VIDX_W;

  typedef logic [1:0] ctr_t;

  // Counter codes: -2, -1, +1, +2. Taken means the upper bit is set.
  localparam ctr_t CTR_STRONG_NT = 2'd0;
  localparam ctr_t CTR_WEAK_NT   = 2'd1;
  localparam ctr_t CTR_WEAK_T    = 2'd2;
  localparam ctr_t CTR_STRONG_T  = 2'd3;

  typedef struct packed {
    logic        func;
    logic        taken;
    logic [31:0] reg_value;
  } hvbp_in_t;

  typedef struct packed {
    logic predicted_taken;
    logic mispredicted;
    logic used_value_table;
  } hvbp_out_t;

  function automatic ctr_t ctr_train(ctr_t c, logic t);
    ctr_t r;
    r = c;
    if (t) begin
      if (c != CTR_STRONG_T) r = c + 2'd1;
    end else begin
      if (c != CTR_STRONG_NT) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

### design/history_and_value_branch_predictor_top.sv
// History and value branch predictor: pattern table, value table and result register.
// Depends on hvbp_pkg.
//
// Takes one resolved branch per clock cycle while req_stall is low. The request is
// registered in stage 1 at the accepting clock edge, and its prediction is then
// loaded into the result register, raising rsp_valid, unless a waiting result
// holds the pipeline. The rate is set by the two counter tables, each a memory
// with one write and one registered read per cycle; a forwarding register covers
// a read that meets the previous request's write.
// After reset both tables are initialized to weakly taken by a pass that steps
// clr_cnt over every index of the larger table, during which req_stall is held high.
module history_and_value_branch_predictor_top
  import hvbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  input  hvbp_in_t  req,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output hvbp_out_t rsp
);

  // Architectural history, updated as each request is accepted; values only for func requests.
  logic [HISTORY_LEN-1:0] outcome_history;
  logic [VALUE_W-1:0]     value_history [VALUE_HISTORY_DEPTH];

  // Counter tables.
  ctr_t pat_mem [PAT_DEPTH];
  ctr_t val_mem [VAL_DEPTH];
  ctr_t pat_rd;
  ctr_t val_rd;

  // Initialization pass.
  logic             clearing;
  logic [CLR_W-1:0] clr_cnt;

  // Stage holding the request while its counters are read.
  logic              s1_vld;
  logic              s1_func;
  logic              s1_taken;
  logic [PIDX_W-1:0] s1_pidx;
  logic [VIDX_W-1:0] s1_vidx;

  // Last write to each table.
  logic              pfwd_vld;
  logic [PIDX_W-1:0] pfwd_addr;
  ctr_t              pfwd_data;
  logic              vfwd_vld;
  logic [VIDX_W-1:0] vfwd_addr;
  ctr_t              vfwd_data;

  logic              accept;
  logic              s1_adv;
  logic [PIDX_W-1:0] pidx;
  logic [VIDX_W-1:0] vidx;
  ctr_t              pc;
  ctr_t              vc;
  ctr_t              pc_next;
  ctr_t              vc_next;
  logic              pc_weak;
  logic              use_value;
  logic              pred;

  assign accept    = req_valid && !req_stall;
  assign s1_adv    = s1_vld && (!rsp_valid || !rsp_stall);
  assign req_stall = clearing || (s1_vld && !s1_adv);

  assign pidx = outcome_history[PIDX_W-1:0];

  always_comb begin
    vidx = '0;
    for (int i = 0; i < VALUE_HISTORY_DEPTH; i++) begin
      vidx = vidx + VIDX_W'(value_history[i] << i);
    end
  end

  // Counters seen by the request in stage 1, with the previous write forwarded.
  always_comb begin
    pc = (pfwd_vld && pfwd_addr == s1_pidx) ? pfwd_data : pat_rd;
    vc = (vfwd_vld && vfwd_addr == s1_vidx) ? vfwd_data : val_rd;
    pc_weak   = (pc == CTR_WEAK_NT) || (pc == CTR_WEAK_T);
    use_value = s1_func && pc_weak;
    pred      = use_value ? vc[1] : pc[1];
    pc_next   = ctr_train(pc, s1_taken);
    vc_next   = ctr_train(vc, s1_taken);
  end

  // Pattern table.
  always_ff @(posedge clk) begin
    if (clearing) begin
      pat_mem[clr_cnt[PIDX_W-1:0]] <= CTR_WEAK_T;
    end else if (s1_adv) begin
      pat_mem[s1_pidx] <= pc_next;
    end
    if (accept) begin
      pat_rd <= pat_mem[pidx];
    end
  end

  // Value table.
  always_ff @(posedge clk) begin
    if (clearing) begin
      val_mem[clr_cnt[VIDX_W-1:0]] <= CTR_WEAK_T;
    end else if (s1_adv) begin
      val_mem[s1_vidx] <= vc_next;
    end
    if (accept) begin
      val_rd <= val_mem[vidx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing        <= 1'b1;
      clr_cnt         <= '0;
      outcome_history <= '0;
      for (int i = 0; i < VALUE_HISTORY_DEPTH; i++) begin
        value_history[i] <= '0;
      end
      s1_vld    <= 1'b0;
      pfwd_vld  <= 1'b0;
      vfwd_vld  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == {CLR_W{1'b1}}) begin
          clearing <= 1'b0;
        end
      end

      if (accept) begin
        outcome_history <= {req.taken, outcome_history[HISTORY_LEN-1:1]};
        if (req.func) begin
          for (int i = 0; i < VALUE_HISTORY_DEPTH - 1; i++) begin
            value_history[i] <= value_history[i+1];
          end
          value_history[VALUE_HISTORY_DEPTH-1] <= req.reg_value[VALUE_W-1:0];
        end
      end

      if (accept) begin
        s1_vld <= 1'b1;
      end else if (s1_adv) begin
        s1_vld <= 1'b0;
      end

      if (s1_adv) begin
        pfwd_vld <= 1'b1;
        vfwd_vld <= 1'b1;
      end

      if (s1_adv) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_func  <= req.func;
      s1_taken <= req.taken;
      s1_pidx  <= pidx;
      s1_vidx  <= vidx;
    end
    if (s1_adv) begin
      pfwd_addr            <= s1_pidx;
      pfwd_data            <= pc_next;
      vfwd_addr            <= s1_vidx;
      vfwd_data            <= vc_next;
      rsp.predicted_taken  <= pred;
      rsp.mispredicted     <= pred ^ s1_taken;
      rsp.used_value_table <= use_value;
    end
  end

`ifndef NO_ASSERTIONS
  // The pipeline stays empty while the tables are being initialized.
  a_empty_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (!s1_vld && !rsp_valid))
    else $error("request in flight during table initialization");

  // A table update never coincides with an initialization write.
  a_no_update_while_clearing: assert property (@(posedge clk) disable iff (rst)
    !(clearing && s1_adv))
    else $error("table update during initialization");

  // Every counter update leaves its value in the forwarding registers.
  a_fwd_after_update: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (pfwd_vld && vfwd_vld && pfwd_addr == $past(s1_pidx)
                && vfwd_addr == $past(s1_vidx)))
    else $error("forwarding register missed a table update");

  // The value table only supplies a prediction for a branch with a value.
  a_value_only_with_func: assert property (@(posedge clk) disable iff (rst)
    s1_adv |=> (!rsp.used_value_table || $past(s1_func)))
    else $error("value table used for a branch without a register value");
`endif

endmodule

### sim/hvbp_prediction_checker.sv
// Checker for the history and value branch predictor: predicts each result and compares.
// Depends on hvbp_pkg for the request/result structs, table sizes and counter codes.
module hvbp_prediction_checker
  import hvbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      req_stall,
  input  hvbp_in_t  req,
  input  logic      rsp_valid,
  input  logic      rsp_stall,
  input  hvbp_out_t rsp,
  output int        mismatches,
  output int        outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [HISTORY_LEN-1:0] outcomes;
  ctr_t                   pattern_ctr [PAT_DEPTH];
  logic [VALUE_W-1:0]     recent_values [VALUE_HISTORY_DEPTH];
  ctr_t                   value_ctr [VAL_DEPTH];
  hvbp_out_t              expected_q [$];

  function automatic ctr_t saturate_step(ctr_t c, logic up);
    if (up) return (c == CTR_STRONG_T) ? c : ctr_t'(c + 2'd1);
    return (c == CTR_STRONG_NT) ? c : ctr_t'(c - 2'd1);
  endfunction

  // Each recent value is weighted by its position; only the low bits of the sum count.
  function automatic logic [VIDX_W-1:0] value_slot();
    logic [31:0] acc;
    acc = '0;
    for (int i = 0; i < VALUE_HISTORY_DEPTH; i++) acc += 32'(recent_values[i]) << i;
    return acc[VIDX_W-1:0];
  endfunction

  function automatic hvbp_out_t predict_branch(hvbp_in_t br);
    logic [PIDX_W-1:0] pidx;
    logic [VIDX_W-1:0] vidx;
    ctr_t              pc;
    logic              via_value;
    hvbp_out_t         res;
    // The newest outcome sits in the top bit and takes no part in the index.
    pidx = outcomes[PIDX_W-1:0];
    vidx = value_slot();
    pc = pattern_ctr[pidx];
    via_value = br.func && (pc == CTR_WEAK_NT || pc == CTR_WEAK_T);
    res.predicted_taken  = via_value ? value_ctr[vidx][1] : pc[1];
    res.mispredicted     = res.predicted_taken ^ br.taken;
    res.used_value_table = via_value;
    if (br.func) begin
      for (int i = 0; i < VALUE_HISTORY_DEPTH - 1; i++) recent_values[i] = recent_values[i + 1];
      recent_values[VALUE_HISTORY_DEPTH - 1] = br.reg_value[VALUE_W-1:0];
    end
    pattern_ctr[pidx] = saturate_step(pc, br.taken);
    value_ctr[vidx] = saturate_step(value_ctr[vidx], br.taken);
    outcomes = {br.taken, outcomes[HISTORY_LEN-1:1]};
    return res;
  endfunction

  always @(posedge clk) begin : watch
    hvbp_out_t want;
    if (rst) begin
      outcomes = '0;
      foreach (pattern_ctr[i]) pattern_ctr[i] = CTR_WEAK_T;
      foreach (value_ctr[i]) value_ctr[i] = CTR_WEAK_T;
      foreach (recent_values[i]) recent_values[i] = '0;
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (req_valid && !req_stall) expected_q.push_back(predict_branch(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_q.size() == 0) begin
          $error("result with no request waiting: %p", rsp);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (rsp.predicted_taken !== want.predicted_taken) begin
            $error("predicted_taken: expected %0b, got %0b",
                   want.predicted_taken, rsp.predicted_taken);
            mismatches++;
          end
          if (rsp.mispredicted !== want.mispredicted) begin
            $error("mispredicted: expected %0b, got %0b", want.mispredicted, rsp.mispredicted);
            mismatches++;
          end
          if (rsp.used_value_table !== want.used_value_table) begin
            $error("used_value_table: expected %0b, got %0b",
                   want.used_value_table, rsp.used_value_table);
            mismatches++;
          end
        end
      end
    end
    outstanding = expected_q.size();
  end

endmodule

### sim/history_and_value_branch_predictor_top_test.sv
// Top of the branch predictor testbench: clock, reset, branch stimulus and verdict.
// Depends on hvbp_pkg, history_and_value_branch_predictor_top and hvbp_prediction_checker.
module history_and_value_branch_predictor_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hvbp_pkg::*;

  localparam int N_RANDOM   = 800;
  localparam int IDLE_PCT   = 38;
  localparam int QUIET_MAX  = 8192;
  localparam int DRAIN      = 8;
  localparam int CALM_FIRST = 350;
  localparam int CALM_LAST  = 500;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  hvbp_in_t  req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  hvbp_out_t rsp;
  int        mismatches;
  int        outstanding;
  logic      calm = 1'b0;
  int        quiet_cycles = 0;
  int        sent_total = 0;

  always #6 clk = ~clk;

  history_and_value_branch_predictor_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  hvbp_prediction_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
  end

  // Covers the clearing pass after reset as well as a hung handshake.
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_MAX) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic issue(input logic f, input logic t, input logic [31:0] v);
    calm <= (sent_total >= CALM_FIRST && sent_total < CALM_LAST);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req.func      <= f;
    req.taken     <= t;
    req.reg_value <= v;
    req_valid     <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_total++;
  endtask

  initial begin
    static logic [31:0] corner_values [8] = '{32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                                              32'h0000_00FF, 32'h7FFF_FFFF, 32'h0000_0001,
                                              32'hFFFF_FF00, 32'h0000_0080};
    int          sent;
    int          run_len;
    int          period;
    int          func_pct;
    logic [7:0]  shape;
    logic [31:0] base;
    logic        t;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Weak pattern counter without a value, then with one, then a strong counter with one.
    issue(1'b0, 1'b0, 32'h0000_0000);
    issue(1'b1, 1'b0, 32'hFFFF_FFFF);
    issue(1'b1, 1'b0, 32'h0000_0100);
    issue(1'b0, 1'b1, 32'hFFFF_FFFF);
    foreach (corner_values[i]) issue(1'b1, 1'b1, corner_values[i]);
    foreach (corner_values[i]) issue(i % 3 != 0, i[0], ~corner_values[i]);

    sent = 0;
    while (sent < N_RANDOM) begin
      run_len = $urandom_range(10, 40);
      if ($urandom_range(9) == 0) begin
        for (int k = 0; k < run_len && sent < N_RANDOM; k++) begin
          issue(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom);
          sent++;
        end
      end else begin
        // A loop-like run: periodic outcomes with a little noise and repeating values.
        period = $urandom_range(1, 8);
        shape = 8'($urandom);
        base = $urandom;
        func_pct = $urandom_range(40, 95);
        for (int k = 0; k < run_len && sent < N_RANDOM; k++) begin
          t = shape[k % period];
          if ($urandom_range(9) == 0) t = ~t;
          issue($urandom_range(99) < func_pct, t,
                ($urandom_range(99) < 60) ? base + 32'(k % period) : $urandom);
          sent++;
        end
      end
    end
    req_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
